@@ hw/rtl/ptrdt_pkg.sv @@
// Shared types and constants for the periodic task release and deadline table.
// Used by the ALU, the table top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package ptrdt_pkg;

   localparam int NUM_TASKS  = 16;
   localparam int TIME_BITS  = 32;
   localparam int IDX_BITS   = 4;
   localparam int CNT_BITS   = 5;
   localparam int ENTRY_BITS = 4 * TIME_BITS;

   // request modes
   localparam logic [2:0] MODE_LOAD     = 3'd0;
   localparam logic [2:0] MODE_FINISH   = 3'd1;
   localparam logic [2:0] MODE_RELEASE  = 3'd2;
   localparam logic [2:0] MODE_DEADLINE = 3'd3;
   localparam logic [2:0] MODE_NEXT     = 3'd4;
   localparam logic [2:0] MODE_RESET    = 3'd5;

   // event kinds
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_RELEASED = 3'd1;
   localparam logic [2:0] KIND_MISSED   = 3'd2;
   localparam logic [2:0] KIND_ANSWER   = 3'd3;

   typedef enum logic [1:0] {
      TASK_IDLE     = 2'd0,
      TASK_READY    = 2'd1,
      TASK_FINISHED = 2'd2
   } task_state_type;

   typedef struct packed {
      logic [2:0]           mode;
      logic [IDX_BITS-1:0]  task_index;
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] first_arrival_in;
      logic [TIME_BITS-1:0] period_in;
      logic [TIME_BITS-1:0] deadline_in;
   } req_type;

   typedef struct packed {
      logic [2:0]          event_kind;
      logic [IDX_BITS-1:0] event_task;
      logic [TIME_BITS:0]  event_time;
      logic                last_result;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] first_arrival;
      logic [TIME_BITS-1:0] arrival_time;
      logic [TIME_BITS-1:0] task_period;
      logic [TIME_BITS-1:0] task_deadline;
   } entry_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic [TIME_BITS-1:0] a;
      logic [TIME_BITS-1:0] b;
   } alu_req_type;

endpackage

@@ hw/rtl/ptrdt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Holds the per-task time words; depends on nothing.
`timescale 1ns / 1ps

module ptrdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ptrdt_alu.sv @@
// Shared add/subtract unit of the task table sequencer.
// Depends on ptrdt_pkg for the request type and time width.
`timescale 1ns / 1ps

module ptrdt_alu (
   input  ptrdt_pkg::alu_req_type           alu_req,
   output logic [ptrdt_pkg::TIME_BITS:0]    alu_result
);

   logic [ptrdt_pkg::TIME_BITS-1:0] b_eff;
   logic                            carry_in;

   // on subtract the top bit is set when a >= b (no borrow)
   always_comb begin
      case (alu_req.op)
         ptrdt_pkg::ALU_ADD: begin
            b_eff    = alu_req.b;
            carry_in = 1'b0;
         end
         ptrdt_pkg::ALU_SUB: begin
            b_eff    = ~alu_req.b;
            carry_in = 1'b1;
         end
         default: begin
            b_eff    = alu_req.b;
            carry_in = 1'b0;
         end
      endcase
      alu_result = {1'b0, alu_req.a} + {1'b0, b_eff}
                 + {{ptrdt_pkg::TIME_BITS{1'b0}}, carry_in};
   end

endmodule

@@ hw/rtl/periodic_task_release_deadline_table.sv @@
// Task table for a real-time scheduler: one request word at a time (load, mark finished,
// release scan, deadline scan, next-arrival query, table reset), taken when start is high and
// busy is low. Each event comes out as one rsp_valid strobe, one cycle wide, that cannot be
// held off; the last word of a request carries last_result, and busy drops in that same cycle.
// Load and mark finished pass S_START, then S_DONE sends their acknowledge word. Scans and the
// query walk entries 0 .. min(task_count, 16) - 1 through one RAM read port and one shared
// adder. Per entry: S_READ, S_EVAL, then in the release scan S_REL_CMP (S_REL_EMIT on a
// release), in the deadline scan S_DL_CMP if due (S_DL_EMIT on a miss), in the query S_NA_CMP
// for a further hit. The one-deep hold of the newest event sets when each scan word appears:
// a word leaves when the next is found. Depends on ptrdt_pkg, ptrdt_ram and ptrdt_alu.
`timescale 1ns / 1ps

module periodic_task_release_deadline_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  ptrdt_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   output ptrdt_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [ptrdt_pkg::CNT_BITS-1:0]        csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_READ,
      S_EVAL,
      S_REL_CMP,
      S_REL_EMIT,
      S_DL_CMP,
      S_DL_EMIT,
      S_NA_CMP,
      S_DONE
   } seq_state_type;

   localparam int TB = ptrdt_pkg::TIME_BITS;

   seq_state_type                       state_ff, state_in;
   ptrdt_pkg::req_type                  req_ff, req_in;
   logic [ptrdt_pkg::IDX_BITS-1:0]      idx_ff, idx_in;
   logic [ptrdt_pkg::CNT_BITS-1:0]      count_ff, count_in;
   ptrdt_pkg::task_state_type           task_state_ff [ptrdt_pkg::NUM_TASKS];
   ptrdt_pkg::task_state_type           task_state_in [ptrdt_pkg::NUM_TASKS];
   logic [ptrdt_pkg::NUM_TASKS-1:0]     missed_ff, missed_in;
   logic [TB-1:0]                       arr_ff, arr_in;
   logic [TB-1:0]                       diff_ff, diff_in;
   logic                                pend_valid_ff, pend_valid_in;
   ptrdt_pkg::rsp_type                  pend_ff, pend_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ptrdt_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                                ram_wr_en;
   logic [ptrdt_pkg::IDX_BITS-1:0]      ram_wr_addr;
   ptrdt_pkg::entry_type                ram_wr_data;
   logic                                ram_rd_en;
   ptrdt_pkg::entry_type                rd_entry;
   ptrdt_pkg::alu_req_type              alu_req;
   logic [TB:0]                         alu_result;

   logic [ptrdt_pkg::CNT_BITS-1:0]      scan_cnt;
   logic                                last_entry;
   seq_state_type                       step_state;
   logic [ptrdt_pkg::IDX_BITS-1:0]      step_idx;
   logic                                index_ok;

   ptrdt_ram #(
      .WIDTH (ptrdt_pkg::ENTRY_BITS),
      .DEPTH (ptrdt_pkg::NUM_TASKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_entry)
   );

   ptrdt_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   assign scan_cnt = (count_ff > ptrdt_pkg::CNT_BITS'(ptrdt_pkg::NUM_TASKS)) ?
                     ptrdt_pkg::CNT_BITS'(ptrdt_pkg::NUM_TASKS) : count_ff;
   assign last_entry = (({1'b0, idx_ff} + ptrdt_pkg::CNT_BITS'(1)) >= scan_cnt);
   assign step_state = last_entry ? S_DONE : S_READ;
   assign step_idx   = last_entry ? idx_ff : idx_ff + ptrdt_pkg::IDX_BITS'(1);
   assign index_ok   = ({1'b0, req_ff.task_index} < ptrdt_pkg::CNT_BITS'(ptrdt_pkg::NUM_TASKS));

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      task_state_in = task_state_ff;
      missed_in     = missed_ff;
      arr_in        = arr_ff;
      diff_in       = diff_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = rd_entry;
      ram_rd_en     = 1'b0;
      alu_req       = '{op: ptrdt_pkg::ALU_ADD, a: '0, b: '0};

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_data;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = S_START;
            end
         end
         S_START: begin
            case (req_ff.mode)
               ptrdt_pkg::MODE_LOAD: begin
                  if (index_ok) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = req_ff.task_index;
                     ram_wr_data = '{first_arrival: req_ff.first_arrival_in,
                                     arrival_time:  req_ff.first_arrival_in,
                                     task_period:   req_ff.period_in,
                                     task_deadline: req_ff.deadline_in};
                     task_state_in[req_ff.task_index] = ptrdt_pkg::TASK_IDLE;
                     missed_in[req_ff.task_index]     = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in = '{event_kind: ptrdt_pkg::KIND_NONE, event_task: req_ff.task_index,
                              event_time: '0, last_result: 1'b0};
                  state_in = S_DONE;
               end
               ptrdt_pkg::MODE_FINISH: begin
                  if (index_ok) begin
                     task_state_in[req_ff.task_index] = ptrdt_pkg::TASK_FINISHED;
                  end
                  pend_valid_in = 1'b1;
                  pend_in = '{event_kind: ptrdt_pkg::KIND_NONE, event_task: req_ff.task_index,
                              event_time: '0, last_result: 1'b0};
                  state_in = S_DONE;
               end
               ptrdt_pkg::MODE_RELEASE, ptrdt_pkg::MODE_DEADLINE,
               ptrdt_pkg::MODE_NEXT, ptrdt_pkg::MODE_RESET: begin
                  state_in = (scan_cnt == '0) ? S_DONE : S_READ;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            case (req_ff.mode)
               ptrdt_pkg::MODE_RELEASE: begin
                  alu_req = '{op: ptrdt_pkg::ALU_ADD, a: rd_entry.arrival_time,
                              b: rd_entry.task_period};
                  if (task_state_ff[idx_ff] == ptrdt_pkg::TASK_FINISHED &&
                      rd_entry.task_period != '0) begin
                     // re-arm a finished periodic task one period later
                     arr_in      = alu_result[TB-1:0];
                     ram_wr_en   = 1'b1;
                     ram_wr_data = '{first_arrival: rd_entry.first_arrival,
                                     arrival_time:  alu_result[TB-1:0],
                                     task_period:   rd_entry.task_period,
                                     task_deadline: rd_entry.task_deadline};
                     task_state_in[idx_ff] = ptrdt_pkg::TASK_IDLE;
                     missed_in[idx_ff]     = 1'b0;
                  end else begin
                     arr_in = rd_entry.arrival_time;
                  end
                  state_in = S_REL_CMP;
               end
               ptrdt_pkg::MODE_DEADLINE: begin
                  alu_req = '{op: ptrdt_pkg::ALU_SUB, a: req_ff.now, b: rd_entry.arrival_time};
                  diff_in = alu_result[TB-1:0];
                  if (task_state_ff[idx_ff] == ptrdt_pkg::TASK_READY && !missed_ff[idx_ff] &&
                      alu_result[TB]) begin
                     state_in = S_DL_CMP;
                  end else begin
                     state_in = step_state;
                     idx_in   = step_idx;
                  end
               end
               ptrdt_pkg::MODE_NEXT: begin
                  alu_req = '{op: ptrdt_pkg::ALU_SUB, a: rd_entry.arrival_time, b: req_ff.now};
                  diff_in = alu_result[TB-1:0];
                  state_in = step_state;
                  idx_in   = step_idx;
                  if (alu_result[TB] && alu_result[TB-1:0] != '0) begin
                     if (pend_valid_ff) begin
                        state_in = S_NA_CMP;
                        idx_in   = idx_ff;
                     end else begin
                        pend_valid_in = 1'b1;
                        pend_in = '{event_kind: ptrdt_pkg::KIND_ANSWER, event_task: idx_ff,
                                    event_time: {1'b0, alu_result[TB-1:0]},
                                    last_result: 1'b0};
                     end
                  end
               end
               ptrdt_pkg::MODE_RESET: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = '{first_arrival: rd_entry.first_arrival,
                                  arrival_time:  rd_entry.first_arrival,
                                  task_period:   rd_entry.task_period,
                                  task_deadline: rd_entry.task_deadline};
                  task_state_in[idx_ff] = ptrdt_pkg::TASK_IDLE;
                  state_in = step_state;
                  idx_in   = step_idx;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_REL_CMP: begin
            alu_req = '{op: ptrdt_pkg::ALU_SUB, a: req_ff.now, b: arr_ff};
            if (task_state_ff[idx_ff] == ptrdt_pkg::TASK_IDLE && alu_result[TB]) begin
               task_state_in[idx_ff] = ptrdt_pkg::TASK_READY;
               state_in = S_REL_EMIT;
            end else begin
               state_in = step_state;
               idx_in   = step_idx;
            end
         end
         S_REL_EMIT: begin
            alu_req = '{op: ptrdt_pkg::ALU_ADD, a: rd_entry.task_deadline, b: req_ff.now};
            // the held word goes out, the new event takes its place
            rsp_valid_in  = pend_valid_ff;
            rsp_in        = pend_ff;
            pend_valid_in = 1'b1;
            pend_in = '{event_kind: ptrdt_pkg::KIND_RELEASED, event_task: idx_ff,
                        event_time: alu_result, last_result: 1'b0};
            state_in = step_state;
            idx_in   = step_idx;
         end
         S_DL_CMP: begin
            alu_req = '{op: ptrdt_pkg::ALU_SUB, a: rd_entry.task_deadline, b: diff_ff};
            if (!alu_result[TB]) begin
               state_in = S_DL_EMIT;
            end else begin
               state_in = step_state;
               idx_in   = step_idx;
            end
         end
         S_DL_EMIT: begin
            alu_req = '{op: ptrdt_pkg::ALU_ADD, a: rd_entry.arrival_time,
                        b: rd_entry.task_deadline};
            rsp_valid_in  = pend_valid_ff;
            rsp_in        = pend_ff;
            pend_valid_in = 1'b1;
            pend_in = '{event_kind: ptrdt_pkg::KIND_MISSED, event_task: idx_ff,
                        event_time: alu_result, last_result: 1'b0};
            missed_in[idx_ff]     = 1'b1;
            task_state_in[idx_ff] = ptrdt_pkg::TASK_FINISHED;
            state_in = step_state;
            idx_in   = step_idx;
         end
         S_NA_CMP: begin
            alu_req = '{op: ptrdt_pkg::ALU_SUB, a: diff_ff, b: pend_ff.event_time[TB-1:0]};
            // strictly smaller gap wins, so ties keep the lower index
            if (!alu_result[TB]) begin
               pend_in = '{event_kind: ptrdt_pkg::KIND_ANSWER, event_task: idx_ff,
                           event_time: {1'b0, diff_ff}, last_result: 1'b0};
            end
            state_in = step_state;
            idx_in   = step_idx;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_in = pend_ff;
            end else begin
               rsp_in = '{event_kind: ptrdt_pkg::KIND_NONE, event_task: '0,
                          event_time: '0, last_result: 1'b0};
            end
            rsp_in.last_result = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      arr_ff  <= arr_in;
      diff_ff <= diff_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         task_state_ff <= '{default: ptrdt_pkg::TASK_IDLE};
         missed_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         task_state_ff <= task_state_in;
         missed_ff     <= missed_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/ptrdt_checker.sv @@
// Port-level checks for the task table, attached to the top level by bind.
// Depends on ptrdt_pkg and periodic_task_release_deadline_table.
`timescale 1ns / 1ps

module ptrdt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input ptrdt_pkg::rsp_type             rsp_data
);

   // the final word of a request comes with busy already low
   a_last_frees : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_result |-> !busy)
      else $error("last word shown while still busy");

   // words before the last only come from scans, while busy
   a_mid_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |->
         busy && (rsp_data.event_kind == ptrdt_pkg::KIND_RELEASED ||
                  rsp_data.event_kind == ptrdt_pkg::KIND_MISSED))
      else $error("non-final word outside a scan");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // when busy drops, a final word is shown in that same cycle
   a_end_word : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid && rsp_data.last_result)
      else $error("busy dropped without a final word");

endmodule

bind periodic_task_release_deadline_table ptrdt_checker u_checker (.*);
